// ===== sv/ptt_pkg.sv =====
// shared types, constants and helpers for the periodic/one-shot timer table
// no dependencies
`timescale 1ns / 1ps
package ptt_pkg;
  localparam int SLOTS   = 16;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int TIME_W  = 48;
  localparam int TGT_W   = 16;
  localparam int DLY_W   = 32;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SCHED  = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;

  typedef struct packed {
    logic [TGT_W-1:0]  target;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] intvl;
  } entry_t;

  // control of one table row
  typedef struct packed {
    logic   step;     // rotate head out, keep or drop it
    logic   keep;     // head goes back in at the tail
    entry_t head_new; // head after reload
    logic   append;   // write new entry at count
    entry_t app;
  } row_ctrl_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction
endpackage

// ===== sv/ptt_cell.sv =====
// one timer entry cell: loads from its neighbor or from an injected entry
// depends on ptt_pkg
`timescale 1ns / 1ps
module ptt_cell import ptt_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  logic   sel_inj,
  input  entry_t nb,
  input  entry_t inj,
  output entry_t q
);
  entry_t q_r;
  entry_t q_nxt;

  // pick source of next entry
  always_comb begin
    q_nxt = q_r;
    if (en) begin
      q_nxt = sel_inj ? inj : nb;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;
endmodule

// ===== sv/ptt_row.sv =====
// one ordered timer table as a row of cells with a fill count
// depends on ptt_pkg, ptt_cell
`timescale 1ns / 1ps
module ptt_row import ptt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  row_ctrl_t        ctrl,
  output entry_t           head,
  output logic [CNT_W-1:0] count
);
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  entry_t           cell_q [SLOTS];

  genvar j;
  generate
    for (j = 0; j < SLOTS; j++) begin : g_cell
      logic   en;
      logic   sel_inj;
      entry_t nb;
      entry_t inj;
      // tail of the live part takes the kept head; append writes at count
      always_comb begin
        en      = 1'b0;
        sel_inj = 1'b0;
        inj     = ctrl.app;
        if (ctrl.step) begin
          en      = 1'b1;
          sel_inj = ctrl.keep && (count_r == CNT_W'(j + 1));
          inj     = ctrl.head_new;
        end else if (ctrl.append && count_r == CNT_W'(j)) begin
          en      = 1'b1;
          sel_inj = 1'b1;
        end
      end
      if (j == SLOTS - 1) begin : g_end
        assign nb = cell_q[j];
      end else begin : g_mid
        assign nb = cell_q[j + 1];
      end
      ptt_cell u_cell (
        .clk    (clk),
        .en     (en),
        .sel_inj(sel_inj),
        .nb     (nb),
        .inj    (inj),
        .q      (cell_q[j])
      );
    end
  endgenerate

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.step && !ctrl.keep) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (ctrl.append) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = cell_q[0];
  assign count = count_r;
endmodule

// ===== sv/periodic_oneshot_timer_table_top.sv =====
// periodic/one-shot timer tables, real-time and game-time
// a cancel passes once over its table; a schedule passes over its table, then appends or
// reports a full table; a tick passes over the game table if game time is present, then
// over the real table, then flushes the held result; one request at a time, accepted only
// while idle; each row rotates one entry per cycle unless an output stall holds it back
// reset: clock and both fill counts cleared, entry cells are not reset
// depends on ptt_pkg, ptt_row
`timescale 1ns / 1ps
module periodic_oneshot_timer_table_top import ptt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // target_id[15:0] delay[47:16] periodic[48] tick_delta[80:49]
  // game time[128:81] game_time_present[129]
  input  logic [135:0] in_tdata,
  // mode[1:0] table_sel[2]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // fired_target[15:0]
  output logic [15:0]  out_tdata,
  // fired_kind[0] status[1]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
  typedef enum logic [1:0] {S_IDLE, S_PASS, S_APPEND, S_FLUSH} state_t;

  state_t           state_r;
  logic [1:0]       mode_r;
  logic             sel_r;
  logic [TGT_W-1:0] tgt_r;
  logic [DLY_W-1:0] dly_r;
  logic             per_r;
  logic [TIME_W-1:0] gnow_r;
  logic [TIME_W-1:0] clock_r;
  logic [CNT_W-1:0] rem_r;
  logic             pend_v_r;
  logic [TGT_W-1:0] pend_tgt_r;
  logic             pend_kind_r;
  logic             pend_st_r;
  logic             out_v_r;
  logic [TGT_W-1:0] out_tgt_r;
  logic             out_kind_r;
  logic             out_st_r;
  logic             out_last_r;

  row_ctrl_t        ctrl_real;
  row_ctrl_t        ctrl_game;
  entry_t           head_real;
  entry_t           head_game;
  logic [CNT_W-1:0] cnt_real;
  logic [CNT_W-1:0] cnt_game;

  ptt_row u_real (.clk(clk), .rst_n(rst_n), .ctrl(ctrl_real), .head(head_real),
                  .count(cnt_real));
  ptt_row u_game (.clk(clk), .rst_n(rst_n), .ctrl(ctrl_game), .head(head_game),
                  .count(cnt_game));

  // head evaluation for the current pass
  entry_t            head;
  entry_t            head_new;
  entry_t            app;
  logic [TIME_W-1:0] now;
  logic [CNT_W-1:0]  cnt_sel;
  logic              fire;
  logic              keep;
  logic              out_free;
  logic              can_step;
  logic              do_step;
  logic              do_app;
  logic              out_load;

  always_comb begin
    head     = sel_r ? head_game : head_real;
    cnt_sel  = sel_r ? cnt_game : cnt_real;
    now      = sel_r ? gnow_r : clock_r;
    fire     = (mode_r == MODE_TICK) && (head.due <= now);
    head_new = head;
    keep     = 1'b1;
    if (mode_r == MODE_TICK) begin
      if (fire) begin
        head_new.due = sat_add(head.due, head.intvl);
        keep         = (head.intvl != '0);
      end
    end else begin
      keep = (head.target != tgt_r);
    end
    out_free = !out_v_r || out_tready;
    can_step = !fire || !pend_v_r || out_free;
    do_step  = (state_r == S_PASS) && (rem_r != '0) && can_step;
    do_app   = (state_r == S_APPEND) && (cnt_sel < CNT_W'(SLOTS));
    // output register takes the held result
    out_load = (do_step && fire && pend_v_r) ||
               ((state_r == S_FLUSH) && pend_v_r && out_free);
    // new entry for a schedule
    app.target = tgt_r;
    app.due    = sat_add(sel_r ? gnow_r : clock_r, {{(TIME_W-DLY_W){1'b0}}, dly_r});
    app.intvl  = (per_r && dly_r != '0) ? {{(TIME_W-DLY_W){1'b0}}, dly_r} : '0;
  end

  // row controls
  always_comb begin
    ctrl_real          = '0;
    ctrl_game          = '0;
    ctrl_real.keep     = keep;
    ctrl_game.keep     = keep;
    ctrl_real.head_new = head_new;
    ctrl_game.head_new = head_new;
    ctrl_real.app      = app;
    ctrl_game.app      = app;
    ctrl_real.step     = do_step && !sel_r;
    ctrl_game.step     = do_step && sel_r;
    ctrl_real.append   = do_app && !sel_r;
    ctrl_game.append   = do_app && sel_r;
  end

  // sequencer, result holding stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      clock_r  <= '0;
      rem_r    <= '0;
      sel_r    <= 1'b0;
      mode_r   <= MODE_TICK;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_load || (out_v_r && !out_tready);
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r <= in_tuser[1:0];
            tgt_r  <= in_tdata[15:0];
            dly_r  <= in_tdata[47:16];
            per_r  <= in_tdata[48];
            gnow_r <= in_tdata[129] ? in_tdata[128:81] : '0;
            case (in_tuser[1:0])
              MODE_TICK: begin
                clock_r <= sat_add(clock_r, {{(TIME_W-DLY_W){1'b0}}, in_tdata[80:49]});
                sel_r   <= in_tdata[129];
                rem_r   <= in_tdata[129] ? cnt_game : cnt_real;
                state_r <= S_PASS;
              end
              MODE_SCHED, MODE_CANCEL: begin
                sel_r   <= in_tuser[2];
                rem_r   <= in_tuser[2] ? cnt_game : cnt_real;
                state_r <= S_PASS;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_PASS: begin
          if (rem_r == '0) begin
            if (mode_r == MODE_TICK && sel_r) begin
              sel_r <= 1'b0;
              rem_r <= cnt_real;
            end else if (mode_r == MODE_TICK) begin
              state_r <= S_FLUSH;
            end else if (mode_r == MODE_SCHED) begin
              state_r <= S_APPEND;
            end else begin
              state_r <= S_IDLE;
            end
          end else if (do_step) begin
            rem_r <= rem_r - CNT_W'(1);
            if (fire) begin
              if (pend_v_r) begin
                out_tgt_r  <= pend_tgt_r;
                out_kind_r <= pend_kind_r;
                out_st_r   <= pend_st_r;
                out_last_r <= 1'b0;
              end
              pend_v_r    <= 1'b1;
              pend_tgt_r  <= head.target;
              pend_kind_r <= sel_r;
              pend_st_r   <= 1'b0;
            end
          end
        end
        S_APPEND: begin
          if (do_app) begin
            state_r <= S_IDLE;
          end else begin
            pend_v_r    <= 1'b1;
            pend_tgt_r  <= tgt_r;
            pend_kind_r <= sel_r;
            pend_st_r   <= 1'b1;
            state_r     <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_tgt_r  <= pend_tgt_r;
            out_kind_r <= pend_kind_r;
            out_st_r   <= pend_st_r;
            out_last_r <= 1'b1;
            pend_v_r   <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_tgt_r;
  assign out_tuser  = {out_st_r, out_kind_r};
  assign out_tlast  = out_last_r;
endmodule
